FILE: hdl/lbpr_pkg.sv
// shared types and constants for the led blink and pwm ramp unit
package lbpr_pkg;

  localparam int LED_PATTERN_W = 8;
  localparam int DUTY_W        = 8;
  localparam int DUTY_OUTS     = 3;
  localparam int BLINK_CNT_W   = 16;
  localparam int RAMP_CNT_W    = 8;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [15:0] BLINK_PERIOD_RST  = 16'd500;
  localparam logic [7:0]  RAMP_INTERVAL_RST = 8'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BLINK_PERIOD  = 2'd0,
    CFG_RAMP_INTERVAL = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LED    = 2'd1,
    OP_TARGET = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    LED_ON     = 2'd0,
    LED_OFF    = 2'd1,
    LED_TOGGLE = 2'd2,
    LED_BLINK  = 2'd3
  } led_mode_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] led_index;
    logic [1:0] led_mode;
    logic [1:0] channel;
    logic [7:0] target_value;
  } in_t;

  typedef struct packed {
    logic [7:0] led_pattern;
    logic [7:0] duty_a;
    logic [7:0] duty_b;
    logic [7:0] duty_c;
  } out_t;

endpackage

FILE: hdl/led_blink_and_pwm_ramp_unit.sv
// top level of the led blink and pwm ramp unit
//
// Input channel in_valid/in_ready/in_data carries one command per transfer:
// a tick, an led command (on, off, toggle, blink) or a duty target write.
// Every accepted command gives exactly one result on out_valid/out_ready/
// out_data: the led pattern and the three ramped duties after the update.
// The result is registered: it is valid in the cycle after the input
// transfer. The unit takes one item per cycle while out_ready is high;
// the state update is a single level of counter compares and one-step
// duty moves ahead of the result register.
// in_ready stays high while the result register is empty or being drained,
// so a new item is taken in the same cycle a waiting result is transferred.
// When the receiver stalls, the result holds and in_ready drops until it
// is taken.
// cfg_we/cfg_index/cfg_wdata write blink_period (index 0) or
// ramp_interval (index 1), one per write; write them only while the unit is idle.
// Synchronous reset clears the leds, blink mask, counters and duties and
// loads blink_period 500 and ramp_interval 8; no result is pending after it.
module led_blink_and_pwm_ramp_unit #(
  parameter int LED_COUNT     = 8,
  parameter int RAMP_CHANNELS = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lbpr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lbpr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lbpr_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lbpr_pkg::out_t                    out_data
);

  logic           in_fire;
  logic           out_valid_r, out_valid_nxt;
  lbpr_pkg::out_t out_data_r;
  lbpr_pkg::out_t res_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  lbpr_core #(
    .LED_COUNT     (LED_COUNT),
    .RAMP_CHANNELS (RAMP_CHANNELS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .res_nxt   (res_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("transfer in gave no result");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_fire)
    else $error("input taken over a pending result");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !in_fire |=> !out_valid_r)
    else $error("result repeated after transfer");

endmodule

FILE: hdl/lbpr_core.sv
// state registers, configuration registers and per-item update logic
module lbpr_core #(
  parameter int LED_COUNT     = 8,
  parameter int RAMP_CHANNELS = 3
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [lbpr_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [lbpr_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_fire,
  input  lbpr_pkg::in_t                          in_data,
  output lbpr_pkg::out_t                         res_nxt
);

  logic [15:0]                            blink_period_r;
  logic [7:0]                             ramp_interval_r;
  logic [LED_COUNT-1:0]                   led_r, led_nxt;
  logic [LED_COUNT-1:0]                   mask_r, mask_nxt;
  logic [lbpr_pkg::BLINK_CNT_W-1:0]       blink_cnt_r, blink_cnt_nxt;
  logic [lbpr_pkg::RAMP_CNT_W-1:0]        ramp_cnt_r, ramp_cnt_nxt;
  logic [lbpr_pkg::DUTY_W-1:0]            duty_now_r [RAMP_CHANNELS];
  logic [lbpr_pkg::DUTY_W-1:0]            duty_now_nxt [RAMP_CHANNELS];
  logic [lbpr_pkg::DUTY_W-1:0]            duty_tgt_r [RAMP_CHANNELS];
  logic [lbpr_pkg::DUTY_W-1:0]            duty_tgt_nxt [RAMP_CHANNELS];

  logic [lbpr_pkg::BLINK_CNT_W-1:0]       blink_inc;
  logic                                   ramp_step;
  logic [LED_COUNT-1:0]                   led_bit;
  logic                                   led_in_range;
  logic [lbpr_pkg::LED_PATTERN_W-1:0]     led_pat;
  logic [lbpr_pkg::DUTY_W-1:0]            duty_out [lbpr_pkg::DUTY_OUTS];

  assign blink_inc    = blink_cnt_r + lbpr_pkg::BLINK_CNT_W'(1);
  assign ramp_step    = (ramp_cnt_r >= ramp_interval_r);
  assign led_bit      = LED_COUNT'(1) << in_data.led_index;
  assign led_in_range = (int'(in_data.led_index) < LED_COUNT);

  always_comb begin
    led_nxt       = led_r;
    mask_nxt      = mask_r;
    blink_cnt_nxt = blink_cnt_r;
    ramp_cnt_nxt  = ramp_cnt_r;
    duty_now_nxt  = duty_now_r;
    duty_tgt_nxt  = duty_tgt_r;
    unique case (in_data.operation)
      lbpr_pkg::OP_TICK: begin
        if (blink_inc == blink_period_r) begin
          led_nxt       = led_r ^ mask_r;
          blink_cnt_nxt = '0;
        end else begin
          blink_cnt_nxt = blink_inc;
        end
        if (ramp_step) begin
          ramp_cnt_nxt = lbpr_pkg::RAMP_CNT_W'(1);
          for (int c = 0; c < RAMP_CHANNELS; c++) begin
            if (duty_tgt_r[c] > duty_now_r[c]) begin
              duty_now_nxt[c] = duty_now_r[c] + lbpr_pkg::DUTY_W'(1);
            end else if (duty_tgt_r[c] < duty_now_r[c]) begin
              duty_now_nxt[c] = duty_now_r[c] - lbpr_pkg::DUTY_W'(1);
            end
          end
        end else begin
          ramp_cnt_nxt = ramp_cnt_r + lbpr_pkg::RAMP_CNT_W'(1);
        end
      end
      lbpr_pkg::OP_LED: begin
        if (led_in_range) begin
          unique case (lbpr_pkg::led_mode_t'(in_data.led_mode))
            lbpr_pkg::LED_ON: begin
              led_nxt  = led_r | led_bit;
              mask_nxt = mask_r & ~led_bit;
            end
            lbpr_pkg::LED_OFF: begin
              led_nxt  = led_r & ~led_bit;
              mask_nxt = mask_r & ~led_bit;
            end
            lbpr_pkg::LED_TOGGLE: begin
              led_nxt = led_r ^ led_bit;
            end
            lbpr_pkg::LED_BLINK: begin
              mask_nxt = mask_r | led_bit;
            end
          endcase
        end
      end
      lbpr_pkg::OP_TARGET: begin
        for (int c = 0; c < RAMP_CHANNELS; c++) begin
          if (int'(in_data.channel) == c) begin
            duty_tgt_nxt[c] = in_data.target_value;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_period_r  <= lbpr_pkg::BLINK_PERIOD_RST;
      ramp_interval_r <= lbpr_pkg::RAMP_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbpr_pkg::CFG_BLINK_PERIOD:  blink_period_r  <= cfg_wdata[15:0];
        lbpr_pkg::CFG_RAMP_INTERVAL: ramp_interval_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r       <= '0;
      mask_r      <= '0;
      blink_cnt_r <= '0;
      ramp_cnt_r  <= '0;
      for (int c = 0; c < RAMP_CHANNELS; c++) begin
        duty_now_r[c] <= '0;
        duty_tgt_r[c] <= '0;
      end
    end else if (in_fire) begin
      led_r       <= led_nxt;
      mask_r      <= mask_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      ramp_cnt_r  <= ramp_cnt_nxt;
      duty_now_r  <= duty_now_nxt;
      duty_tgt_r  <= duty_tgt_nxt;
    end
  end

  // result view taken after this item's update
  if (LED_COUNT >= lbpr_pkg::LED_PATTERN_W) begin : g_led_wide
    assign led_pat = led_nxt[lbpr_pkg::LED_PATTERN_W-1:0];
  end else begin : g_led_narrow
    assign led_pat = {{(lbpr_pkg::LED_PATTERN_W-LED_COUNT){1'b0}}, led_nxt};
  end

  for (genvar k = 0; k < lbpr_pkg::DUTY_OUTS; k++) begin : g_duty
    if (k < RAMP_CHANNELS) begin : g_present
      assign duty_out[k] = duty_now_nxt[k];
    end else begin : g_absent
      assign duty_out[k] = '0;
    end
  end

  assign res_nxt.led_pattern = led_pat;
  assign res_nxt.duty_a      = duty_out[0];
  assign res_nxt.duty_b      = duty_out[1];
  assign res_nxt.duty_c      = duty_out[2];

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && in_data.operation == lbpr_pkg::OP_TICK) |=> $stable(blink_cnt_r)
                                                            && $stable(ramp_cnt_r))
    else $error("counters moved without a tick");

  a_ramp_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.operation == lbpr_pkg::OP_TICK && ramp_step
      |=> ramp_cnt_r == lbpr_pkg::RAMP_CNT_W'(1))
    else $error("ramp divider did not restart");

  a_duty_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && in_data.operation == lbpr_pkg::OP_TICK && ramp_step)
      |=> $stable(duty_now_r[0]))
    else $error("duty changed outside a ramp step");

  a_mask_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && in_data.operation == lbpr_pkg::OP_LED) |=> $stable(mask_r))
    else $error("blink mask changed without an led command");

endmodule

FILE: sim/led_blink_and_pwm_ramp_unit_tb.sv
// self-checking testbench for the led blink and pwm ramp unit
module led_blink_and_pwm_ramp_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                       OP_NONE     = 2'd3;
  localparam logic [lbpr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [lbpr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int                               MAX_PRINTS  = 40;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [lbpr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [lbpr_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  lbpr_pkg::in_t                    in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  lbpr_pkg::out_t                   out_data;

  led_blink_and_pwm_ramp_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lbpr_pkg::in_t  pending_cmds [$];
  lbpr_pkg::out_t expected_status [$];

  // predicted unit state
  logic [lbpr_pkg::BLINK_CNT_W-1:0]   period_q;
  logic [lbpr_pkg::RAMP_CNT_W-1:0]    interval_q;
  logic [lbpr_pkg::LED_PATTERN_W-1:0] led_q;
  logic [lbpr_pkg::LED_PATTERN_W-1:0] blink_q;
  logic [lbpr_pkg::BLINK_CNT_W-1:0]   blink_cnt;
  logic [lbpr_pkg::RAMP_CNT_W-1:0]    ramp_cnt;
  logic [lbpr_pkg::DUTY_W-1:0]        duty_q   [lbpr_pkg::DUTY_OUTS];
  logic [lbpr_pkg::DUTY_W-1:0]        target_q [lbpr_pkg::DUTY_OUTS];

  logic in_xfer = 1'b0;
  bit   calm = 1'b0;
  int   stall_pct = 0;
  int   stall_max = 1;
  int   burst_left = 1;
  int   gap_left = 0;
  int   stall_left = 0;
  int   err_count = 0;
  int   cmd_count = 0;
  int   tick_count = 0;
  int   status_count = 0;
  int   reg_writes = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic flag_mismatch(string msg);
    if (err_count < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic lbpr_pkg::out_t predict_status(lbpr_pkg::in_t cmd);
    lbpr_pkg::out_t                     res;
    logic [lbpr_pkg::LED_PATTERN_W-1:0] bit_sel;
    bit_sel = 8'd1 << cmd.led_index;
    case (cmd.operation)
      lbpr_pkg::OP_TICK: begin
        blink_cnt = blink_cnt + 16'd1;
        if (blink_cnt == period_q) begin
          led_q = led_q ^ blink_q;
          blink_cnt = '0;
        end
        if (ramp_cnt >= interval_q) begin
          ramp_cnt = '0;
          for (int c = 0; c < lbpr_pkg::DUTY_OUTS; c++) begin
            if (target_q[c] > duty_q[c]) duty_q[c] = duty_q[c] + 8'd1;
            else if (target_q[c] < duty_q[c]) duty_q[c] = duty_q[c] - 8'd1;
          end
        end
        ramp_cnt = ramp_cnt + 8'd1;
      end
      lbpr_pkg::OP_LED: begin
        case (cmd.led_mode)
          lbpr_pkg::LED_ON: begin
            led_q = led_q | bit_sel;
            blink_q = blink_q & ~bit_sel;
          end
          lbpr_pkg::LED_OFF: begin
            led_q = led_q & ~bit_sel;
            blink_q = blink_q & ~bit_sel;
          end
          lbpr_pkg::LED_TOGGLE: led_q = led_q ^ bit_sel;
          default: blink_q = blink_q | bit_sel;
        endcase
      end
      lbpr_pkg::OP_TARGET: begin
        if (cmd.channel < lbpr_pkg::DUTY_OUTS) target_q[cmd.channel] = cmd.target_value;
      end
      default: ;
    endcase
    res.led_pattern = led_q;
    res.duty_a = duty_q[0];
    res.duty_b = duty_q[1];
    res.duty_c = duty_q[2];
    return res;
  endfunction

  // monitor: checks status transfers, tracks register writes and commands
  always @(posedge clk) begin
    lbpr_pkg::out_t want;
    lbpr_pkg::out_t got;
    in_xfer <= rst_n && in_valid && in_ready;
    if (!rst_n) begin
      period_q = lbpr_pkg::BLINK_PERIOD_RST;
      interval_q = lbpr_pkg::RAMP_INTERVAL_RST;
      led_q = '0;
      blink_q = '0;
      blink_cnt = '0;
      ramp_cnt = '0;
      for (int c = 0; c < lbpr_pkg::DUTY_OUTS; c++) begin
        duty_q[c] = '0;
        target_q[c] = '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        status_count++;
        if (expected_status.size() == 0) begin
          flag_mismatch($sformatf("status transfer with nothing expected: %h", got));
        end else begin
          want = expected_status.pop_front();
          if (got.led_pattern !== want.led_pattern)
            flag_mismatch($sformatf("led_pattern %h, want %h", got.led_pattern,
                                    want.led_pattern));
          if (got.duty_a !== want.duty_a)
            flag_mismatch($sformatf("duty_a %h, want %h", got.duty_a, want.duty_a));
          if (got.duty_b !== want.duty_b)
            flag_mismatch($sformatf("duty_b %h, want %h", got.duty_b, want.duty_b));
          if (got.duty_c !== want.duty_c)
            flag_mismatch($sformatf("duty_c %h, want %h", got.duty_c, want.duty_c));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          lbpr_pkg::CFG_BLINK_PERIOD:  period_q = cfg_wdata;
          lbpr_pkg::CFG_RAMP_INTERVAL: interval_q = cfg_wdata[lbpr_pkg::RAMP_CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        cmd_count++;
        if (in_data.operation == lbpr_pkg::OP_TICK) tick_count++;
        expected_status.push_back(predict_status(in_data));
      end
    end
  end

  // driver: bursts of commands with random gaps
  always @(negedge clk) begin
    logic          nv;
    lbpr_pkg::in_t nd;
    nv = in_valid;
    nd = in_data;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_valid || in_xfer) begin
      nv = 1'b0;
      if (gap_left > 0 && !calm) begin
        gap_left--;
      end else if (pending_cmds.size() > 0) begin
        nv = 1'b1;
        nd = pending_cmds.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = $urandom_range(1, 8);
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, stall_max);
    end
  end

  function automatic lbpr_pkg::in_t make_cmd(logic [1:0] op, logic [2:0] idx,
                                             logic [1:0] mode, logic [1:0] ch,
                                             logic [7:0] val);
    lbpr_pkg::in_t cmd;
    cmd.operation = op;
    cmd.led_index = idx;
    cmd.led_mode = mode;
    cmd.channel = ch;
    cmd.target_value = val;
    return cmd;
  endfunction

  function automatic lbpr_pkg::in_t random_cmd(int tick_pct);
    lbpr_pkg::in_t cmd;
    int            pick;
    cmd = make_cmd(lbpr_pkg::OP_TICK, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) cmd.target_value = $urandom_range(0, 1) ? 8'hff : 8'h00;
    pick = $urandom_range(0, 99);
    if (pick < tick_pct) cmd.operation = lbpr_pkg::OP_TICK;
    else if (pick < tick_pct + (100 - tick_pct) * 6 / 10) cmd.operation = lbpr_pkg::OP_LED;
    else if (pick < 95) cmd.operation = lbpr_pkg::OP_TARGET;
    else cmd.operation = OP_NONE;
    return cmd;
  endfunction

  task automatic set_pace(bit quiet, int pct, int longest);
    calm = quiet;
    stall_pct = pct;
    stall_max = longest;
  endtask

  task automatic settle();
    while (pending_cmds.size() != 0 || in_valid || expected_status.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [lbpr_pkg::CFG_INDEX_W-1:0] idx,
                           logic [lbpr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  task automatic run_random(int n, int tick_pct);
    @(posedge clk);
    repeat (n) pending_cmds.push_back(random_cmd(tick_pct));
    settle();
  endtask

  task automatic run_ticks(int n);
    @(posedge clk);
    repeat (n) pending_cmds.push_back(random_cmd(100));
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, field extremes, every mode and the ignored cases
    set_pace(1'b0, 20, 4);
    @(posedge clk);
    pending_cmds.push_back(make_cmd(OP_NONE, 3'd5, lbpr_pkg::LED_TOGGLE, 2'd1, 8'haa));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_TARGET, 3'd0, lbpr_pkg::LED_ON, 2'd0, 8'hff));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_TARGET, 3'd7, lbpr_pkg::LED_BLINK, 2'd1,
                                    8'h00));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_TARGET, 3'd2, lbpr_pkg::LED_OFF, 2'd2, 8'h80));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_TARGET, 3'd1, lbpr_pkg::LED_ON, 2'd3, 8'h4d));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_LED, 3'd0, lbpr_pkg::LED_ON, 2'd3, 8'hff));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_LED, 3'd7, lbpr_pkg::LED_ON, 2'd0, 8'h00));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_LED, 3'd7, lbpr_pkg::LED_OFF, 2'd0, 8'h00));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_LED, 3'd3, lbpr_pkg::LED_TOGGLE, 2'd2, 8'h11));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_LED, 3'd3, lbpr_pkg::LED_TOGGLE, 2'd2, 8'h11));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_LED, 3'd1, lbpr_pkg::LED_BLINK, 2'd1, 8'h22));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_LED, 3'd6, lbpr_pkg::LED_BLINK, 2'd1, 8'h22));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_LED, 3'd6, lbpr_pkg::LED_ON, 2'd1, 8'h22));
    repeat (11) pending_cmds.push_back(make_cmd(lbpr_pkg::OP_TICK, 3'd7, lbpr_pkg::LED_BLINK,
                                                2'd3, 8'hff));
    settle();

    set_pace(1'b0, 35, 3);
    write_reg(lbpr_pkg::CFG_BLINK_PERIOD, 16'd1);
    write_reg(lbpr_pkg::CFG_RAMP_INTERVAL, 16'd0);
    run_random(200, 45);

    set_pace(1'b1, 0, 1);
    write_reg(lbpr_pkg::CFG_BLINK_PERIOD, 16'd3);
    write_reg(lbpr_pkg::CFG_RAMP_INTERVAL, 16'd255);
    run_random(200, 60);

    // unknown register indexes must leave the settings alone
    set_pace(1'b0, 8, 20);
    write_reg(lbpr_pkg::CFG_BLINK_PERIOD, 16'hffff);
    write_reg(lbpr_pkg::CFG_RAMP_INTERVAL, 16'd1);
    write_reg(CFG_SPARE_A, 16'h0003);
    write_reg(CFG_SPARE_B, 16'h5a5a);
    run_random(200, 45);

    set_pace(1'b0, 25, 6);
    write_reg(lbpr_pkg::CFG_BLINK_PERIOD, 16'd7);
    write_reg(lbpr_pkg::CFG_RAMP_INTERVAL, 16'd2);
    run_random(250, 50);

    // period lowered below the running count, then a zero period
    set_pace(1'b1, 0, 1);
    write_reg(lbpr_pkg::CFG_BLINK_PERIOD, 16'd1000);
    write_reg(lbpr_pkg::CFG_RAMP_INTERVAL, 16'd5);
    @(posedge clk);
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_LED, 3'd0, lbpr_pkg::LED_BLINK, 2'd0, 8'h00));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_LED, 3'd2, lbpr_pkg::LED_BLINK, 2'd0, 8'h00));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_LED, 3'd5, lbpr_pkg::LED_BLINK, 2'd0, 8'h00));
    pending_cmds.push_back(make_cmd(lbpr_pkg::OP_TARGET, 3'd0, lbpr_pkg::LED_ON, 2'd1, 8'hc8));
    run_ticks(100);
    write_reg(lbpr_pkg::CFG_BLINK_PERIOD, 16'd5);
    run_ticks(50);
    write_reg(lbpr_pkg::CFG_BLINK_PERIOD, 16'd0);
    write_reg(lbpr_pkg::CFG_RAMP_INTERVAL, 16'd3);
    run_ticks(50);

    set_pace(1'b0, 45, 10);
    write_reg(lbpr_pkg::CFG_BLINK_PERIOD, 16'd2);
    write_reg(lbpr_pkg::CFG_RAMP_INTERVAL, 16'd4);
    run_random(250, 50);

    repeat (5) @(posedge clk);
    if (expected_status.size() != 0)
      flag_mismatch($sformatf("%0d expected status transfers never came",
                              expected_status.size()));
    $display("covered %0d commands (%0d ticks) over %0d register writes",
             cmd_count, tick_count, reg_writes);
    $display("%0d status transfers compared under sender gaps and receiver stalls",
             status_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: led_blink_and_pwm_ramp_unit.f
hdl/lbpr_pkg.sv
hdl/lbpr_core.sv
hdl/led_blink_and_pwm_ramp_unit.sv
sim/led_blink_and_pwm_ramp_unit_tb.sv
